[src/imu_cal_pkg.sv]
// imu_cal_pkg: shared types and constants for the imu offset calibration block
// payload structs, sizes, reset offsets and the constant reciprocal for the average
// no dependencies
package imu_cal_pkg;

	localparam int SAMPLE_COUNT = 200;

	localparam int NUM_AXES = 3;
	localparam int DATA_W   = 16;
	localparam int SUM_W    = 24;
	localparam int CNT_W    = 8;
	localparam int GRAV_W   = 15;

	localparam logic [GRAV_W-1:0] GRAV_RST = 15'd8192;

	localparam logic signed [DATA_W-1:0] ACCEL_OFF_RST [NUM_AXES] = '{16'sd9, -16'sd259, -16'sd969};
	localparam logic signed [DATA_W-1:0] GYRO_OFF_RST  [NUM_AXES] = '{-16'sd33, 16'sd10, 16'sd14};

	// magnitude of a sum stays below 2^(SUM_W-1)
	localparam int MAG_W       = SUM_W - 1;
	localparam int DIV_SHIFT   = MAG_W + $clog2(SAMPLE_COUNT);
	localparam int DIV_RECIP_W = SUM_W + 1;
	localparam int PROD_W      = MAG_W + DIV_RECIP_W;
	localparam longint unsigned DIV_RECIP_FULL =
		((64'd1 << DIV_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(DIV_RECIP_FULL);

	typedef struct packed {
		logic signed [DATA_W-1:0] raw_accel_x;
		logic signed [DATA_W-1:0] raw_accel_y;
		logic signed [DATA_W-1:0] raw_accel_z;
		logic signed [DATA_W-1:0] raw_gyro_x;
		logic signed [DATA_W-1:0] raw_gyro_y;
		logic signed [DATA_W-1:0] raw_gyro_z;
		logic                     start_calibration;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_accel_x;
		logic signed [DATA_W-1:0] out_accel_y;
		logic signed [DATA_W-1:0] out_accel_z;
		logic signed [DATA_W-1:0] out_gyro_x;
		logic signed [DATA_W-1:0] out_gyro_y;
		logic signed [DATA_W-1:0] out_gyro_z;
		logic                     calibrating;
		logic                     calibration_done;
		logic signed [DATA_W-1:0] new_offset_x;
		logic signed [DATA_W-1:0] new_offset_y;
		logic signed [DATA_W-1:0] new_offset_z;
	} out_item_t;

endpackage

[src/imu_offset_calibrate_correct_top.sv]
// imu_offset_calibrate_correct_top: offset correction and bias calibration for six imu axes
// depends on imu_cal_pkg for payload types, reset offsets and the divide constants
//
// Every transfer in gives exactly one transfer out, in order, through the input register and then
// the result register; one item can be taken on every clock while the output is not stalled: the
// input and result registers each hold one item, so a new sample is taken while a finished result
// waits. Each result carries the raw sample minus the per-axis offsets in force before it (16-bit
// wrap). A sample with start_calibration set clears the sums and opens a calibration window of
// SAMPLE_COUNT samples, itself the first; the sums are built as samples are taken in. On the last
// sample of the window each offset becomes its sum divided by SAMPLE_COUNT, truncated toward zero,
// with gravity_counts also taken off the Z accelerometer offset; that result raises
// calibration_done and reports the three new accelerometer offsets, and the very next sample is
// corrected with them. The divide is a multiply by a constant reciprocal in the stage after the
// input register, one multiplier per sum. gravity_counts is written through cfg_we/cfg_wdata, by
// the user only while no item is in flight; the block itself does not enforce this.
module imu_offset_calibrate_correct_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  imu_cal_pkg::in_item_t                in_data,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output imu_cal_pkg::out_item_t               out_data,
	// gravity_counts register
	input  logic                                 cfg_we,
	input  logic [imu_cal_pkg::GRAV_W-1:0]       cfg_wdata
);

	// ---------------------------------------------------------------
	// divide a sum by the sample count, truncated toward zero, wrapped
	// ---------------------------------------------------------------
	function automatic logic [imu_cal_pkg::DATA_W-1:0] div_count(
		input logic signed [imu_cal_pkg::SUM_W-1:0] sum
	);
		logic [imu_cal_pkg::SUM_W-1:0]  mag;
		logic [imu_cal_pkg::PROD_W-1:0] prod;
		logic [imu_cal_pkg::DATA_W-1:0] quo;
		mag  = sum[imu_cal_pkg::SUM_W-1] ? imu_cal_pkg::SUM_W'(-sum) : imu_cal_pkg::SUM_W'(sum);
		prod = imu_cal_pkg::PROD_W'(mag[imu_cal_pkg::MAG_W-1:0])
			* imu_cal_pkg::PROD_W'(imu_cal_pkg::DIV_RECIP);
		quo  = prod[imu_cal_pkg::DIV_SHIFT +: imu_cal_pkg::DATA_W];
		return sum[imu_cal_pkg::SUM_W-1] ? imu_cal_pkg::DATA_W'(-quo) : quo;
	endfunction

	// configuration
	logic [imu_cal_pkg::GRAV_W-1:0] gravity_q;

	// calibration state
	logic signed [imu_cal_pkg::SUM_W-1:0]  accel_sum_q [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::SUM_W-1:0]  gyro_sum_q  [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] accel_off_q [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] gyro_off_q  [imu_cal_pkg::NUM_AXES];
	logic [imu_cal_pkg::CNT_W-1:0]         cnt_q;
	logic                                  calib_active_q;

	// input stage
	logic                    valid_s1;
	imu_cal_pkg::in_item_t   item_s1;
	logic                    calibrating_s1;
	logic                    done_s1;

	// result stage
	logic                    out_valid_q;
	imu_cal_pkg::out_item_t  out_data_q;

	// handshake
	logic in_xfer;
	logic out_load;
	logic s1_adv;

	// accumulate side
	logic signed [imu_cal_pkg::DATA_W-1:0] in_accel [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] in_gyro  [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::SUM_W-1:0]  accel_sum_nxt [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::SUM_W-1:0]  gyro_sum_nxt  [imu_cal_pkg::NUM_AXES];
	logic [imu_cal_pkg::CNT_W-1:0]         cnt_inc;
	logic                                  cal_go;
	logic                                  cal_end;

	// stage-1 side
	logic signed [imu_cal_pkg::DATA_W-1:0] s1_accel [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] s1_gyro  [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] corr_accel [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] corr_gyro  [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] new_accel  [imu_cal_pkg::NUM_AXES];
	logic signed [imu_cal_pkg::DATA_W-1:0] new_gyro   [imu_cal_pkg::NUM_AXES];

	// ---------------------------------------------------------------
	// handshake: result register frees when empty or being taken,
	// input register frees when empty or moving on
	// ---------------------------------------------------------------
	assign out_load  = !out_valid_q || !out_stall;
	assign s1_adv    = valid_s1 && out_load;
	assign in_stall  = valid_s1 && !out_load;
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------
	// sums and sample count update as the sample is taken in, so the
	// input register sees the finished sums of its own sample
	// ---------------------------------------------------------------
	always_comb begin
		in_accel[0] = in_data.raw_accel_x;
		in_accel[1] = in_data.raw_accel_y;
		in_accel[2] = in_data.raw_accel_z;
		in_gyro[0]  = in_data.raw_gyro_x;
		in_gyro[1]  = in_data.raw_gyro_y;
		in_gyro[2]  = in_data.raw_gyro_z;

		// a start restarts the window even inside a running one
		cal_go  = in_data.start_calibration || calib_active_q;
		cnt_inc = (in_data.start_calibration ? '0 : cnt_q) + imu_cal_pkg::CNT_W'(1);
		cal_end = cal_go && (cnt_inc >= imu_cal_pkg::CNT_W'(imu_cal_pkg::SAMPLE_COUNT));

		for (int i = 0; i < imu_cal_pkg::NUM_AXES; i++) begin
			accel_sum_nxt[i] = (in_data.start_calibration ? '0 : accel_sum_q[i])
				+ imu_cal_pkg::SUM_W'(in_accel[i]);
			gyro_sum_nxt[i]  = (in_data.start_calibration ? '0 : gyro_sum_q[i])
				+ imu_cal_pkg::SUM_W'(in_gyro[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			calib_active_q <= 1'b0;
			for (int i = 0; i < imu_cal_pkg::NUM_AXES; i++) begin
				accel_sum_q[i] <= '0;
				gyro_sum_q[i]  <= '0;
			end
		end else if (in_xfer && cal_go) begin
			cnt_q          <= cal_end ? '0 : cnt_inc;
			calib_active_q <= !cal_end;
			for (int i = 0; i < imu_cal_pkg::NUM_AXES; i++) begin
				accel_sum_q[i] <= accel_sum_nxt[i];
				gyro_sum_q[i]  <= gyro_sum_nxt[i];
			end
		end
	end

	// gravity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= imu_cal_pkg::GRAV_RST;
		end else if (cfg_we) begin
			gravity_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1        <= in_data;
			calibrating_s1 <= cal_go && !cal_end;
			done_s1        <= cal_end;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: correction with current offsets, new offsets on the
	// closing sample (sums are held while this item sits here)
	// ---------------------------------------------------------------
	always_comb begin
		s1_accel[0] = item_s1.raw_accel_x;
		s1_accel[1] = item_s1.raw_accel_y;
		s1_accel[2] = item_s1.raw_accel_z;
		s1_gyro[0]  = item_s1.raw_gyro_x;
		s1_gyro[1]  = item_s1.raw_gyro_y;
		s1_gyro[2]  = item_s1.raw_gyro_z;

		for (int i = 0; i < imu_cal_pkg::NUM_AXES; i++) begin
			corr_accel[i] = s1_accel[i] - accel_off_q[i];
			corr_gyro[i]  = s1_gyro[i] - gyro_off_q[i];
			new_accel[i]  = div_count(accel_sum_q[i]);
			new_gyro[i]   = div_count(gyro_sum_q[i]);
		end
		// one g comes off the z accelerometer offset
		new_accel[2] = new_accel[2] - imu_cal_pkg::DATA_W'(gravity_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < imu_cal_pkg::NUM_AXES; i++) begin
				accel_off_q[i] <= imu_cal_pkg::ACCEL_OFF_RST[i];
				gyro_off_q[i]  <= imu_cal_pkg::GYRO_OFF_RST[i];
			end
		end else if (s1_adv && done_s1) begin
			for (int i = 0; i < imu_cal_pkg::NUM_AXES; i++) begin
				accel_off_q[i] <= new_accel[i];
				gyro_off_q[i]  <= new_gyro[i];
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.out_accel_x      <= corr_accel[0];
			out_data_q.out_accel_y      <= corr_accel[1];
			out_data_q.out_accel_z      <= corr_accel[2];
			out_data_q.out_gyro_x       <= corr_gyro[0];
			out_data_q.out_gyro_y       <= corr_gyro[1];
			out_data_q.out_gyro_z       <= corr_gyro[2];
			out_data_q.calibrating      <= calibrating_s1;
			out_data_q.calibration_done <= done_s1;
			out_data_q.new_offset_x     <= done_s1 ? new_accel[0] : '0;
			out_data_q.new_offset_y     <= done_s1 ? new_accel[1] : '0;
			out_data_q.new_offset_z     <= done_s1 ? new_accel[2] : '0;
		end
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < imu_cal_pkg::CNT_W'(imu_cal_pkg::SAMPLE_COUNT))
		else $error("sample count left the calibration window");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!calib_active_q |-> cnt_q == '0)
		else $error("sample count nonzero outside calibration");

	a_done_not_calibrating: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.calibration_done && out_data_q.calibrating))
		else $error("result both closing and still calibrating");

	a_offset_matches_report: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && done_s1 |=> accel_off_q[0] == out_data_q.new_offset_x
			&& accel_off_q[2] == out_data_q.new_offset_z)
		else $error("stored offsets differ from reported offsets");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with free register space");

endmodule
